@@ sv/ucep_pkg.sv @@
`timescale 1ns / 1ps

package ucep_pkg;

    localparam int IN_TDATA_W  = 96;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 112;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int NUM_STR     = 4;

    typedef enum logic [1:0] {
        MODE_SETUP     = 2'd0,
        MODE_IN_DONE   = 2'd1,
        MODE_OUT_DONE  = 2'd2,
        MODE_BUS_RESET = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_DATA       = 3'd1,
        ACT_STATUS_OUT = 3'd2,
        ACT_SET_ADDR   = 3'd3,
        ACT_SET_CONFIG = 3'd4,
        ACT_SET_LINE   = 3'd5
    } t_in_act;

    typedef enum logic [1:0] {
        USB_UNCONNECTED = 2'd0,
        USB_ATTACHED    = 2'd1,
        USB_ADDRESSED   = 2'd2,
        USB_CONFIGURED  = 2'd3
    } t_usb_state;

    localparam logic [7:0] REQ_SET_ADDRESS      = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR   = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIG       = 8'h09;
    localparam logic [7:0] REQ_SET_LINE_CODING  = 8'h20;
    localparam logic [7:0] REQ_GET_LINE_CODING  = 8'h21;
    localparam logic [7:0] REQ_SET_CTRL_LINE    = 8'h22;

    localparam logic [7:0] DESC_DEVICE    = 8'h01;
    localparam logic [7:0] DESC_CONFIG    = 8'h02;
    localparam logic [7:0] DESC_STRING    = 8'h03;
    localparam logic [7:0] DESC_QUALIFIER = 8'h06;

    localparam logic [2:0] SRC_NONE    = 3'd0;
    localparam logic [2:0] SRC_DEVICE  = 3'd1;
    localparam logic [2:0] SRC_CONFIG  = 3'd2;
    localparam logic [2:0] SRC_STRING0 = 3'd3;
    localparam logic [2:0] SRC_LINE    = 3'd7;

    localparam logic [15:0] LINE_CODING_LEN = 16'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_LANG_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_LEN  = 2'd3;

    localparam logic [7:0] LANG_LEN_RESET = 8'd4;

    typedef logic [NUM_STR-1:0][7:0] t_str_len;

    typedef struct packed {
        t_in_act    in_act;
        logic       out_pend;
        logic [15:0] remaining;
        logic [15:0] offset;
        logic [2:0]  source;
        logic [6:0]  saved_addr;
        logic [6:0]  active_addr;
        logic [7:0]  config_val;
        logic [7:0]  line_state;
        logic [55:0] line_coding;
        t_usb_state  usb_state;
        logic        indicator;
    } t_state;

    typedef struct packed {
        logic        tx_arm;
        logic [6:0]  tx_count;
        logic        rx_arm;
        logic [2:0]  source;
        logic [15:0] offset;
    } t_result;

endpackage

@@ sv/ucep_step.sv @@
`timescale 1ns / 1ps

module ucep_step #(
    parameter int MAX_PACKET = 64
) (
    input  ucep_pkg::t_state   i_state,
    input  ucep_pkg::t_str_len i_str_len,
    input  ucep_pkg::t_mode    i_mode,
    input  logic [7:0]         i_request_code,
    input  logic [7:0]         i_value_low,
    input  logic [7:0]         i_value_high,
    input  logic [15:0]        i_request_length,
    input  logic [55:0]        i_out_payload,
    output ucep_pkg::t_state   o_state,
    output ucep_pkg::t_result  o_result
);

    localparam logic [15:0] MaxLen = 16'(MAX_PACKET);

    logic        plan_en;
    logic [2:0]  plan_src;
    logic [15:0] plan_rem;
    logic [15:0] plan_off;
    logic [15:0] plan_len;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        plan_en  = 1'b0;
        plan_src = i_state.source;
        plan_rem = i_state.remaining;
        plan_off = i_state.offset;

        unique case (i_mode)
            ucep_pkg::MODE_SETUP: begin
                unique case (i_request_code)
                    ucep_pkg::REQ_SET_CTRL_LINE: begin
                        o_result.tx_arm     = 1'b1;
                        o_state.in_act      = ucep_pkg::ACT_SET_LINE;
                        o_state.line_state  = i_value_low;
                    end
                    ucep_pkg::REQ_SET_LINE_CODING: begin
                        o_state.out_pend = 1'b1;
                        o_result.rx_arm  = 1'b1;
                    end
                    ucep_pkg::REQ_GET_LINE_CODING: begin
                        plan_en  = 1'b1;
                        plan_src = ucep_pkg::SRC_LINE;
                        plan_rem = ucep_pkg::LINE_CODING_LEN;
                        plan_off = '0;
                    end
                    ucep_pkg::REQ_SET_CONFIG: begin
                        o_state.config_val = i_value_low;
                        o_result.tx_arm    = 1'b1;
                        o_state.in_act     = ucep_pkg::ACT_SET_CONFIG;
                    end
                    ucep_pkg::REQ_SET_ADDRESS: begin
                        o_state.saved_addr = i_value_low[6:0];
                        o_result.tx_arm    = 1'b1;
                        o_state.in_act     = ucep_pkg::ACT_SET_ADDR;
                    end
                    ucep_pkg::REQ_GET_DESCRIPTOR: begin
                        priority if (i_value_high == ucep_pkg::DESC_DEVICE) begin
                            plan_en  = 1'b1;
                            plan_src = ucep_pkg::SRC_DEVICE;
                            plan_rem = i_request_length;
                            plan_off = '0;
                        end else if (i_value_high == ucep_pkg::DESC_QUALIFIER) begin
                            o_result.tx_arm = 1'b1;
                            o_state.in_act  = ucep_pkg::ACT_STATUS_OUT;
                        end else if (i_value_high == ucep_pkg::DESC_CONFIG) begin
                            plan_en  = 1'b1;
                            plan_src = ucep_pkg::SRC_CONFIG;
                            plan_rem = i_request_length;
                            plan_off = '0;
                        end else if (i_value_high == ucep_pkg::DESC_STRING
                                     && i_value_low[7:2] == 6'd0) begin
                            plan_en  = 1'b1;
                            plan_src = ucep_pkg::SRC_STRING0 + {1'b0, i_value_low[1:0]};
                            plan_rem = {8'd0, i_str_len[i_value_low[1:0]]};
                            plan_off = '0;
                        end else begin
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ucep_pkg::MODE_IN_DONE: begin
                unique case (i_state.in_act)
                    ucep_pkg::ACT_DATA: begin
                        plan_en = 1'b1;
                    end
                    ucep_pkg::ACT_STATUS_OUT: begin
                        o_result.rx_arm  = 1'b1;
                        o_state.in_act   = ucep_pkg::ACT_NONE;
                        o_state.out_pend = 1'b0;
                    end
                    ucep_pkg::ACT_SET_ADDR: begin
                        o_state.active_addr = i_state.saved_addr;
                        o_state.usb_state   = ucep_pkg::USB_ADDRESSED;
                        o_result.rx_arm     = 1'b1;
                        o_state.in_act      = ucep_pkg::ACT_NONE;
                    end
                    ucep_pkg::ACT_SET_CONFIG: begin
                        o_state.usb_state = ucep_pkg::USB_CONFIGURED;
                        o_state.indicator = 1'b1;
                        o_result.rx_arm   = 1'b1;
                        o_state.in_act    = ucep_pkg::ACT_NONE;
                    end
                    ucep_pkg::ACT_SET_LINE: begin
                        o_result.rx_arm = 1'b1;
                        o_state.in_act  = ucep_pkg::ACT_NONE;
                    end
                    default: begin
                        o_state.in_act = ucep_pkg::ACT_NONE;
                    end
                endcase
            end
            ucep_pkg::MODE_OUT_DONE: begin
                if (i_state.out_pend) begin
                    o_state.line_coding = i_out_payload;
                    o_result.tx_arm     = 1'b1;
                    o_state.in_act      = ucep_pkg::ACT_NONE;
                    o_state.out_pend    = 1'b0;
                end
                o_result.rx_arm = 1'b1;
            end
            ucep_pkg::MODE_BUS_RESET: begin
                o_state.active_addr = '0;
                o_state.in_act      = ucep_pkg::ACT_NONE;
                o_state.out_pend    = 1'b0;
                o_state.indicator   = 1'b0;
                o_state.usb_state   = ucep_pkg::USB_ATTACHED;
                o_result.rx_arm     = 1'b1;
            end
            default: begin
            end
        endcase

        // cut the next data packet
        plan_len = (plan_rem > MaxLen) ? MaxLen : plan_rem;
        if (plan_en) begin
            o_state.source = plan_src;
            if (plan_len != 16'd0) begin
                o_result.tx_arm   = 1'b1;
                o_result.tx_count = plan_len[6:0];
                o_result.source   = plan_src;
                o_result.offset   = plan_off;
            end
            o_state.remaining = plan_rem - plan_len;
            if (plan_rem != plan_len) begin
                o_state.offset = plan_off + plan_len;
                o_state.in_act = ucep_pkg::ACT_DATA;
            end else begin
                o_state.offset = plan_off;
                o_state.in_act = ucep_pkg::ACT_STATUS_OUT;
            end
        end
    end

endmodule

@@ sv/usb_control_endpoint_sequencer.sv @@
`timescale 1ns / 1ps
// An accepted input beat's result beat is registered; it is valid on the next cycle.
// Throughput: one event per cycle unless a held result waits on m_axis_tready; the
// decode and packet cut sit between the slave port and the output register.
// Reset (i_rst_n low, synchronous): no result pending, device unconnected, address 0,
// stored values cleared, string lengths back to 4, 0, 0, 0.

module usb_control_endpoint_sequencer #(
    parameter int MAX_PACKET = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ucep_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ucep_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // request_code, value_low, value_high, request_length, out_payload
    input  logic [ucep_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // mode
    input  logic [ucep_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tx_arm, tx_count, rx_arm, source_select, source_offset, device_address,
    // device_state, led_on, line_coding, control_line_state, config_value, 2 pad bits
    output logic [ucep_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    ucep_pkg::t_state   r_state;
    ucep_pkg::t_state   n_state;
    ucep_pkg::t_result  n_result;
    ucep_pkg::t_str_len r_str_len;
    logic               r_out_valid;
    logic [ucep_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [ucep_pkg::OUT_TDATA_W-1:0] n_out_data;
    logic               in_fire;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    ucep_step #(
        .MAX_PACKET(MAX_PACKET)
    ) u_step (
        .i_state          (r_state),
        .i_str_len        (r_str_len),
        .i_mode           (ucep_pkg::t_mode'(s_axis_tuser[1:0])),
        .i_request_code   (s_axis_tdata[7:0]),
        .i_value_low      (s_axis_tdata[15:8]),
        .i_value_high     (s_axis_tdata[23:16]),
        .i_request_length (s_axis_tdata[39:24]),
        .i_out_payload    (s_axis_tdata[95:40]),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    assign n_out_data = {2'b00,
                         n_state.config_val,
                         n_state.line_state,
                         n_state.line_coding,
                         n_state.indicator,
                         n_state.usb_state,
                         n_state.active_addr,
                         n_result.offset,
                         n_result.source,
                         n_result.rx_arm,
                         n_result.tx_count,
                         n_result.tx_arm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{in_act:    ucep_pkg::ACT_NONE,
                             usb_state: ucep_pkg::USB_UNCONNECTED,
                             default:   '0};
        end else begin
            if (in_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_str_len[ucep_pkg::CFG_LANG_LEN]    <= ucep_pkg::LANG_LEN_RESET;
            r_str_len[ucep_pkg::CFG_VENDOR_LEN]  <= '0;
            r_str_len[ucep_pkg::CFG_PRODUCT_LEN] <= '0;
            r_str_len[ucep_pkg::CFG_SERIAL_LEN]  <= '0;
        end else if (i_cfg_we) begin
            r_str_len[i_cfg_index] <= i_cfg_data;
        end
    end

endmodule

@@ tb/sv/usb_control_endpoint_sequencer_tb.sv @@
`timescale 1ns / 1ps

module usb_control_endpoint_sequencer_tb;
    import ucep_pkg::*;

    localparam int PKT_MAX     = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_START  = 1500;
    localparam int HOLD_LEN    = 400;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  req;
        logic [7:0]  vlo;
        logic [7:0]  vhi;
        logic [15:0] wlen;
        logic [55:0] payload;
    } ep0_event_t;

    typedef struct packed {
        logic        tx_arm;
        logic [6:0]  tx_count;
        logic        rx_arm;
        logic [2:0]  src;
        logic [15:0] off;
        logic [6:0]  addr;
        t_usb_state  state;
        logic        led;
        logic [55:0] coding;
        logic [7:0]  line_state;
        logic [7:0]  cfg;
    } ep0_reply_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    usb_control_endpoint_sequencer #(
        .MAX_PACKET(PKT_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // endpoint model state, post-reset values
    t_in_act     ep_in_act      = ACT_NONE;
    logic        ep_out_pend    = 1'b0;
    logic [15:0] ep_remaining   = '0;
    logic [15:0] ep_offset      = '0;
    logic [2:0]  ep_source      = SRC_NONE;
    logic [6:0]  ep_saved_addr  = '0;
    logic [6:0]  ep_addr        = '0;
    logic [7:0]  ep_cfg         = '0;
    logic [7:0]  ep_line_state  = '0;
    logic [55:0] ep_coding      = '0;
    t_usb_state  ep_state       = USB_UNCONNECTED;
    logic        ep_led         = 1'b0;
    t_str_len    ep_str_len     = {8'd0, 8'd0, 8'd0, LANG_LEN_RESET};

    ep0_event_t  pending_events[$];
    ep0_reply_t  replies_due[$];
    ep0_event_t  drv_ev;
    ep0_reply_t  want;
    ep0_reply_t  seen;

    int  n_pushed    = 0;
    int  n_accepted  = 0;
    int  n_checked   = 0;
    int  errors      = 0;
    int  src_gap     = 0;
    int  sink_gap    = 0;
    int  hold_clock  = 0;
    int  cycle_count = 0;
    bit  idle_on     = 1'b1;
    logic hold_off   = 1'b0;

    logic [7:0] known_reqs [6] = '{REQ_SET_ADDRESS, REQ_GET_DESCRIPTOR, REQ_SET_CONFIG,
                                   REQ_SET_LINE_CODING, REQ_GET_LINE_CODING,
                                   REQ_SET_CTRL_LINE};

    function automatic void cut_packet(inout ep0_reply_t r);
        logic [15:0] len;
        len = (ep_remaining > 16'(PKT_MAX)) ? 16'(PKT_MAX) : ep_remaining;
        if (len != 0) begin
            r.tx_arm   = 1'b1;
            r.tx_count = len[6:0];
            r.src      = ep_source;
            r.off      = ep_offset;
        end
        ep_remaining = ep_remaining - len;
        if (ep_remaining != 0) begin
            ep_offset = ep_offset + len;
            ep_in_act = ACT_DATA;
        end else begin
            ep_in_act = ACT_STATUS_OUT;
        end
    endfunction

    function automatic void start_stage(input logic [2:0] src, input logic [15:0] len,
                                        inout ep0_reply_t r);
        ep_source    = src;
        ep_remaining = len;
        ep_offset    = '0;
        cut_packet(r);
    endfunction

    function automatic ep0_reply_t ep_step(input ep0_event_t ev);
        ep0_reply_t r;
        r = '0;
        case (ev.mode)
            MODE_SETUP: begin
                case (ev.req)
                    REQ_SET_CTRL_LINE: begin
                        r.tx_arm      = 1'b1;
                        ep_in_act     = ACT_SET_LINE;
                        ep_line_state = ev.vlo;
                    end
                    REQ_SET_LINE_CODING: begin
                        ep_out_pend = 1'b1;
                        r.rx_arm    = 1'b1;
                    end
                    REQ_GET_LINE_CODING: start_stage(SRC_LINE, LINE_CODING_LEN, r);
                    REQ_SET_CONFIG: begin
                        ep_cfg    = ev.vlo;
                        r.tx_arm  = 1'b1;
                        ep_in_act = ACT_SET_CONFIG;
                    end
                    REQ_SET_ADDRESS: begin
                        ep_saved_addr = ev.vlo[6:0];
                        r.tx_arm      = 1'b1;
                        ep_in_act     = ACT_SET_ADDR;
                    end
                    REQ_GET_DESCRIPTOR: begin
                        if (ev.vhi == DESC_DEVICE) begin
                            start_stage(SRC_DEVICE, ev.wlen, r);
                        end else if (ev.vhi == DESC_QUALIFIER) begin
                            r.tx_arm  = 1'b1;
                            ep_in_act = ACT_STATUS_OUT;
                        end else if (ev.vhi == DESC_CONFIG) begin
                            start_stage(SRC_CONFIG, ev.wlen, r);
                        end else if (ev.vhi == DESC_STRING && ev.vlo < NUM_STR) begin
                            start_stage(SRC_STRING0 + ev.vlo[2:0],
                                        {8'd0, ep_str_len[ev.vlo[1:0]]}, r);
                        end
                    end
                    default: ;
                endcase
            end
            MODE_IN_DONE: begin
                case (ep_in_act)
                    ACT_DATA: cut_packet(r);
                    ACT_STATUS_OUT: begin
                        r.rx_arm    = 1'b1;
                        ep_in_act   = ACT_NONE;
                        ep_out_pend = 1'b0;
                    end
                    ACT_SET_ADDR: begin
                        ep_addr   = ep_saved_addr;
                        ep_state  = USB_ADDRESSED;
                        r.rx_arm  = 1'b1;
                        ep_in_act = ACT_NONE;
                    end
                    ACT_SET_CONFIG: begin
                        ep_state  = USB_CONFIGURED;
                        ep_led    = 1'b1;
                        r.rx_arm  = 1'b1;
                        ep_in_act = ACT_NONE;
                    end
                    ACT_SET_LINE: begin
                        r.rx_arm  = 1'b1;
                        ep_in_act = ACT_NONE;
                    end
                    default: ep_in_act = ACT_NONE;
                endcase
            end
            MODE_OUT_DONE: begin
                if (ep_out_pend) begin
                    ep_coding   = ev.payload;
                    r.tx_arm    = 1'b1;
                    ep_in_act   = ACT_NONE;
                    ep_out_pend = 1'b0;
                end
                r.rx_arm = 1'b1;
            end
            default: begin
                ep_addr     = '0;
                ep_in_act   = ACT_NONE;
                ep_out_pend = 1'b0;
                ep_led      = 1'b0;
                ep_state    = USB_ATTACHED;
                r.rx_arm    = 1'b1;
            end
        endcase
        r.addr       = ep_addr;
        r.state      = ep_state;
        r.led        = ep_led;
        r.coding     = ep_coding;
        r.line_state = ep_line_state;
        r.cfg        = ep_cfg;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [55:0] rand56();
        return 56'({$urandom, $urandom});
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // driver: predict on acceptance, then load the next beat or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                replies_due.push_back(ep_step(drv_ev));
                n_accepted++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the beat until taken
            end else if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                drv_ev = pending_events.pop_front();
                s_axis_tdata  <= {drv_ev.payload, drv_ev.wlen, drv_ev.vhi, drv_ev.vlo,
                                  drv_ev.req};
                s_axis_tuser  <= drv_ev.mode;
                s_axis_tvalid <= 1'b1;
                src_gap = idle_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (replies_due.size() == 0) begin
                    $error("result beat with no expectation pending");
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    seen.tx_arm     = m_axis_tdata[0];
                    seen.tx_count   = m_axis_tdata[7:1];
                    seen.rx_arm     = m_axis_tdata[8];
                    seen.src        = m_axis_tdata[11:9];
                    seen.off        = m_axis_tdata[27:12];
                    seen.addr       = m_axis_tdata[34:28];
                    seen.state      = t_usb_state'(m_axis_tdata[36:35]);
                    seen.led        = m_axis_tdata[37];
                    seen.coding     = m_axis_tdata[93:38];
                    seen.line_state = m_axis_tdata[101:94];
                    seen.cfg        = m_axis_tdata[109:102];
                    check_field("tx_arm", 64'(want.tx_arm), 64'(seen.tx_arm));
                    check_field("tx_count", 64'(want.tx_count), 64'(seen.tx_count));
                    check_field("rx_arm", 64'(want.rx_arm), 64'(seen.rx_arm));
                    check_field("source_select", 64'(want.src), 64'(seen.src));
                    check_field("source_offset", 64'(want.off), 64'(seen.off));
                    check_field("device_address", 64'(want.addr), 64'(seen.addr));
                    check_field("device_state", 64'(want.state), 64'(seen.state));
                    check_field("led_on", 64'(want.led), 64'(seen.led));
                    check_field("line_coding", 64'(want.coding), 64'(seen.coding));
                    check_field("control_line_state", 64'(want.line_state),
                                64'(seen.line_state));
                    check_field("config_value", 64'(want.cfg), 64'(seen.cfg));
                    n_checked++;
                end
                sink_gap = idle_len();
            end
            if (hold_off || sink_gap > 0) begin
                if (sink_gap > 0) sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // long receiver stall so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off <= 1'b0;
        end else begin
            hold_clock++;
            hold_off <= (hold_clock >= HOLD_START) && (hold_clock < HOLD_START + HOLD_LEN);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_event(input t_mode m, input logic [7:0] req, input logic [7:0] vlo,
                              input logic [7:0] vhi, input logic [15:0] wlen,
                              input logic [55:0] payload);
        ep0_event_t ev;
        ev.mode    = m;
        ev.req     = req;
        ev.vlo     = vlo;
        ev.vhi     = vhi;
        ev.wlen    = wlen;
        ev.payload = payload;
        pending_events.push_back(ev);
        n_pushed++;
    endtask

    task automatic push_setup(input logic [7:0] req, input logic [7:0] vlo,
                              input logic [7:0] vhi, input logic [15:0] wlen);
        push_event(MODE_SETUP, req, vlo, vhi, wlen, rand56());
    endtask

    task automatic push_in();
        push_event(MODE_IN_DONE, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                   rand56());
    endtask

    task automatic push_out(input logic [55:0] payload);
        push_event(MODE_OUT_DONE, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                   payload);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        ep_str_len[idx] = val;
    endtask

    task automatic set_lengths(input logic [7:0] lang, input logic [7:0] vendor,
                               input logic [7:0] product, input logic [7:0] serial);
        write_reg(CFG_LANG_LEN, lang);
        write_reg(CFG_VENDOR_LEN, vendor);
        write_reg(CFG_PRODUCT_LEN, product);
        write_reg(CFG_SERIAL_LEN, serial);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge i_clk); while (n_accepted != n_pushed || n_checked != n_accepted);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, 200));
        if (r < 85) return 16'($urandom_range(PKT_MAX - 2, 2 * PKT_MAX + 2));
        return 16'($urandom);
    endfunction

    task automatic run_random(input int count);
        int target;
        int kind;
        int n_in;
        logic [15:0] len;
        logic [7:0] idx;
        logic [7:0] vhi;
        target = n_pushed + count;
        while (n_pushed < target) begin
            if ($urandom_range(0, 99) < 15) begin
                vhi = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
                push_event(t_mode'($urandom_range(0, 3)),
                           ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                       : known_reqs[$urandom_range(0, 5)],
                           8'($urandom), vhi, 16'($urandom), rand56());
                continue;
            end
            kind = $urandom_range(0, 10);
            n_in = 1;
            case (kind)
                0, 1: begin
                    len = pick_len();
                    push_setup(REQ_GET_DESCRIPTOR, 8'($urandom),
                               (kind == 0) ? DESC_DEVICE : DESC_CONFIG, len);
                    n_in = (int'(len) + PKT_MAX - 1) / PKT_MAX + 1;
                    // abandon long transfers early
                    if (n_in > 10) n_in = $urandom_range(1, 6);
                end
                2: begin
                    idx = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 3))
                                                      : 8'($urandom_range(4, 255));
                    push_setup(REQ_GET_DESCRIPTOR, idx, DESC_STRING, pick_len());
                    if (idx < NUM_STR)
                        n_in = (int'(ep_str_len[idx[1:0]]) + PKT_MAX - 1) / PKT_MAX + 1;
                end
                3: push_setup(REQ_GET_DESCRIPTOR, 8'($urandom), DESC_QUALIFIER, pick_len());
                4: begin
                    do vhi = 8'($urandom);
                    while (vhi == DESC_DEVICE || vhi == DESC_CONFIG || vhi == DESC_STRING ||
                           vhi == DESC_QUALIFIER);
                    push_setup(REQ_GET_DESCRIPTOR, 8'($urandom), vhi, pick_len());
                end
                5: push_setup(REQ_SET_ADDRESS, 8'($urandom), 8'($urandom), 16'($urandom));
                6: push_setup(REQ_SET_CONFIG, 8'($urandom), 8'($urandom), 16'($urandom));
                7: push_setup(REQ_SET_CTRL_LINE, 8'($urandom), 8'($urandom), 16'($urandom));
                8: begin
                    push_setup(REQ_SET_LINE_CODING, 8'($urandom), 8'($urandom),
                               LINE_CODING_LEN);
                    push_out(rand56());
                end
                9: begin
                    push_setup(REQ_GET_LINE_CODING, 8'($urandom), 8'($urandom),
                               LINE_CODING_LEN);
                    n_in = 2;
                end
                default: begin
                    push_event(MODE_BUS_RESET, 8'($urandom), 8'($urandom), 8'($urandom),
                               16'($urandom), rand56());
                    n_in = 0;
                end
            endcase
            // drop the tail of some transfers
            if (n_in > 0 && $urandom_range(0, 9) == 0) n_in = $urandom_range(0, n_in - 1);
            for (int k = 0; k < n_in; k++) push_in();
            if (kind == 9 && $urandom_range(0, 3) != 0) push_out(rand56());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_setup(REQ_GET_DESCRIPTOR, 8'h00, DESC_DEVICE, 16'd18);
        push_in();
        push_setup(REQ_GET_DESCRIPTOR, 8'h00, DESC_CONFIG, 16'd65);
        push_in();
        push_in();
        push_setup(REQ_GET_DESCRIPTOR, 8'h00, DESC_CONFIG, 16'd0);
        push_in();
        push_setup(REQ_GET_DESCRIPTOR, 8'h00, DESC_QUALIFIER, 16'd10);
        push_in();
        push_setup(REQ_GET_DESCRIPTOR, 8'd0, DESC_STRING, 16'hFFFF);
        push_in();
        push_setup(REQ_GET_DESCRIPTOR, 8'd1, DESC_STRING, 16'd255);
        push_in();
        push_setup(REQ_GET_DESCRIPTOR, 8'd4, DESC_STRING, 16'd255);
        push_setup(REQ_GET_DESCRIPTOR, 8'h00, 8'hFF, 16'd8);
        push_setup(REQ_SET_ADDRESS, 8'hFF, 8'h00, 16'd0);
        push_in();
        push_setup(REQ_SET_CONFIG, 8'hFF, 8'h00, 16'd0);
        push_in();
        push_setup(REQ_SET_CTRL_LINE, 8'hA5, 8'h00, 16'd0);
        push_in();
        push_setup(REQ_SET_LINE_CODING, 8'h00, 8'h00, LINE_CODING_LEN);
        push_out({56{1'b1}});
        push_in();
        push_setup(REQ_GET_LINE_CODING, 8'h00, 8'h00, LINE_CODING_LEN);
        push_in();
        push_out(rand56());
        push_setup(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        push_setup(REQ_GET_DESCRIPTOR, 8'h00, DESC_DEVICE, 16'hFFFF);
        push_in();
        push_event(MODE_BUS_RESET, 8'h00, 8'h00, 8'h00, 16'd0, '0);
        run_random(380);
        drain();

        idle_on = 1'b0;
        set_lengths(8'd0, 8'd255, 8'd64, 8'd63);
        run_random(380);
        drain();

        idle_on = 1'b1;
        set_lengths(8'd255, 8'd255, 8'd255, 8'd255);
        run_random(380);
        drain();

        set_lengths(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(380);
        drain();

        set_lengths(8'd1, 8'd0, 8'd128, 8'd65);
        run_random(380);
        drain();

        if (errors == 0 && replies_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
